// File: design/ila_pkg.sv
// ----------------------------------------------------------------------------
// ila_pkg
// Shared types and constants for the interrupt lane allocator.
// ----------------------------------------------------------------------------
package ila_pkg;

  localparam int LANES_DEF  = 32;
  localparam int TILE_SLOTS = 32;
  localparam int LANE_W     = 5;
  localparam int ADDR_W     = 6;
  localparam int PIN_W      = 7;
  localparam int ENTRY_W    = PIN_W + 1;
  localparam int TBL_DEPTH  = 2 * TILE_SLOTS;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  localparam logic [PIN_W-1:0] FREE_PIN = 7'h7E;
  localparam logic [PIN_W-1:0] MAX_PIN  = 7'd125;

  localparam logic [CFG_IDX_W-1:0] CFG_DUAL_TILE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_PRI   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_SEC   = 2'd2;

  localparam logic ACT_MAP   = 1'b0;
  localparam logic ACT_UNMAP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_LOOKUP     = 3'd1,
    ST_MAPFAIL    = 3'd2,
    ST_NOTMAPPED  = 3'd3,
    ST_SECURITY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic pin_hit;
    logic free_hit;
  } cmp_res_t;

endpackage

// File: design/interrupt_lane_allocator.sv
// ----------------------------------------------------------------------------
// interrupt_lane_allocator
// Maps pins to interrupt lanes of two tiles and unmaps them.
// ----------------------------------------------------------------------------
// A request that fails the tile, pin or secure-pin checks skips the scan and
// goes straight to the done state with a lookup status. Any other request
// scans the tile's lane table one entry per cycle through the table RAM's
// single read port and one lane compare unit, then updates the table if the
// map or unmap succeeds. in_tready returns in the same cycle as out_tvalid.
// The result sits in an output register, so a new request is taken while it
// waits; that request holds its own result, with in_tready low, until the
// register drains. The lane table reads as free after reset through per-entry
// valid bits.
module interrupt_lane_allocator #(
  parameter int LANES = ila_pkg::LANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [6:0] pin, [7] pin_valid, [8] pin_is_secure, [9] requester_secure,
  // [10] positive_edge, [15:11] zero
  input  logic [ila_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] action, [1] tile
  input  logic [ila_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] status, [7:3] lane
  output logic [ila_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [ila_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [ila_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int CNT_W  = $clog2(LANES + 1);
  localparam int LANE_W = ila_pkg::LANE_W;
  localparam int PIN_W  = ila_pkg::PIN_W;
  localparam int ADDR_W = ila_pkg::ADDR_W;

  ila_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [LANE_W-1:0] cmp_lane_r, cmp_lane_nxt;
  logic              rd_valid_r;

  logic              action_r, action_nxt;
  logic              tile_r, tile_nxt;
  logic [PIN_W-1:0]  pin_r, pin_nxt;
  logic              req_sec_r, req_sec_nxt;
  logic              pos_r, pos_nxt;

  logic              hit_r, hit_nxt;
  logic [LANE_W-1:0] hit_lane_r, hit_lane_nxt;
  logic              free_r, free_nxt;
  logic [LANE_W-1:0] free_lane_r, free_lane_nxt;

  ila_pkg::status_t  status_r, status_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;

  logic              out_tvalid_r, out_tvalid_nxt;
  ila_pkg::status_t  out_status_r, out_status_nxt;
  logic [LANE_W-1:0] out_lane_r, out_lane_nxt;

  logic                      dual_r;
  logic [ila_pkg::CFG_W-1:0] sec_pri_r;
  logic [ila_pkg::CFG_W-1:0] sec_sec_r;

  logic [ila_pkg::TBL_DEPTH-1:0] valid_r;

  logic                        issue;
  logic [ADDR_W-1:0]           raddr;
  logic [ADDR_W-1:0]           waddr;
  logic [ila_pkg::ENTRY_W-1:0] rdata;
  logic                        ram_we;
  logic                        vclr;
  logic [ila_pkg::CFG_W-1:0]   mask_sel;
  ila_pkg::cmp_res_t           cmp_res;
  logic                        out_free;
  logic                        in_fire;
  logic                        precheck_fail;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign issue    = (state_r == ila_pkg::S_SCAN) && (cnt_r < CNT_W'(LANES));
  assign raddr    = {tile_r, LANE_W'(cnt_r)};
  assign mask_sel = tile_r ? sec_sec_r : sec_pri_r;

  assign precheck_fail = (in_tuser[1] && !dual_r) ||
                         !in_tdata[7] || (in_tdata[6:0] > ila_pkg::MAX_PIN) ||
                         ((in_tuser[0] == ila_pkg::ACT_MAP) && !in_tdata[9] && in_tdata[8]);

  ila_ram #(
    .WIDTH (ila_pkg::ENTRY_W),
    .DEPTH (ila_pkg::TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({pos_r, pin_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  ila_lane_cmp u_cmp (
    .entry_valid (rd_valid_r),
    .entry_pin   (rdata[PIN_W-1:0]),
    .req_pin     (pin_r),
    .lane_secure (mask_sel[cmp_lane_r]),
    .req_secure  (req_sec_r),
    .res         (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ila_pkg::S_IDLE;
      cnt_r        <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      dual_r       <= 1'b0;
      sec_pri_r    <= '0;
      sec_sec_r    <= '0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      hit_r        <= hit_nxt;
      free_r       <= free_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          ila_pkg::CFG_DUAL_TILE: dual_r    <= cfg_wdata[0];
          ila_pkg::CFG_SEC_PRI:   sec_pri_r <= cfg_wdata;
          ila_pkg::CFG_SEC_SEC:   sec_sec_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (ram_we) begin
        valid_r[waddr] <= 1'b1;
      end else if (vclr) begin
        valid_r[waddr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r   <= valid_r[raddr];
    cmp_lane_r   <= cmp_lane_nxt;
    action_r     <= action_nxt;
    tile_r       <= tile_nxt;
    pin_r        <= pin_nxt;
    req_sec_r    <= req_sec_nxt;
    pos_r        <= pos_nxt;
    hit_lane_r   <= hit_lane_nxt;
    free_lane_r  <= free_lane_nxt;
    status_r     <= status_nxt;
    lane_r       <= lane_nxt;
    out_status_r <= out_status_nxt;
    out_lane_r   <= out_lane_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_lane_nxt   = LANE_W'(cnt_r);
    action_nxt     = action_r;
    tile_nxt       = tile_r;
    pin_nxt        = pin_r;
    req_sec_nxt    = req_sec_r;
    pos_nxt        = pos_r;
    hit_nxt        = hit_r;
    hit_lane_nxt   = hit_lane_r;
    free_nxt       = free_r;
    free_lane_nxt  = free_lane_r;
    status_nxt     = status_r;
    lane_nxt       = lane_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_lane_nxt   = out_lane_r;
    ram_we         = 1'b0;
    vclr           = 1'b0;
    waddr          = {tile_r, free_lane_r};
    in_tready      = 1'b0;

    unique case (state_r)
      ila_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          action_nxt  = in_tuser[0];
          tile_nxt    = in_tuser[1];
          pin_nxt     = in_tdata[6:0];
          req_sec_nxt = in_tdata[9];
          pos_nxt     = in_tdata[10];
          cnt_nxt     = '0;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          lane_nxt    = '0;
          if (precheck_fail) begin
            status_nxt = ila_pkg::ST_LOOKUP;
            state_nxt  = ila_pkg::S_DONE;
          end else begin
            state_nxt = ila_pkg::S_SCAN;
          end
        end
      end
      ila_pkg::S_SCAN: begin
        if (issue) begin
          cnt_nxt     = cnt_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
        end
        if (cmp_vld_r) begin
          if (cmp_res.pin_hit && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_lane_nxt = cmp_lane_r;
          end
          if (cmp_res.free_hit && !free_r) begin
            free_nxt      = 1'b1;
            free_lane_nxt = cmp_lane_r;
          end
        end
        if (!issue && !cmp_vld_r) begin
          state_nxt = ila_pkg::S_DECIDE;
        end
      end
      ila_pkg::S_DECIDE: begin
        state_nxt = ila_pkg::S_DONE;
        lane_nxt  = '0;
        if (action_r == ila_pkg::ACT_MAP) begin
          if (hit_r || !free_r) begin
            status_nxt = ila_pkg::ST_MAPFAIL;
          end else begin
            status_nxt = ila_pkg::ST_OK;
            lane_nxt   = free_lane_r;
            ram_we     = 1'b1;
          end
        end else begin
          waddr = {tile_r, hit_lane_r};
          if (!hit_r) begin
            status_nxt = ila_pkg::ST_NOTMAPPED;
          end else if (mask_sel[hit_lane_r] != req_sec_r) begin
            status_nxt = ila_pkg::ST_SECURITY;
          end else begin
            status_nxt = ila_pkg::ST_OK;
            lane_nxt   = hit_lane_r;
            vclr       = 1'b1;
          end
        end
      end
      ila_pkg::S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_lane_nxt   = lane_r;
          state_nxt      = ila_pkg::S_IDLE;
        end
      end
      default: state_nxt = ila_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_lane_r, out_status_r};

endmodule

// File: design/ila_ram.sv
// ----------------------------------------------------------------------------
// ila_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ila_ram #(
  parameter int WIDTH = ila_pkg::ENTRY_W,
  parameter int DEPTH = ila_pkg::TBL_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/ila_lane_cmp.sv
// ----------------------------------------------------------------------------
// ila_lane_cmp
// Lane compare unit: checks one table entry for a pin match and for a free
// lane of the requested security.
// ----------------------------------------------------------------------------
module ila_lane_cmp (
  input  logic                       entry_valid,
  input  logic [ila_pkg::PIN_W-1:0]  entry_pin,
  input  logic [ila_pkg::PIN_W-1:0]  req_pin,
  input  logic                       lane_secure,
  input  logic                       req_secure,
  output ila_pkg::cmp_res_t          res
);

  logic entry_free;

  // invalid entries read as the free code
  assign entry_free   = !entry_valid || (entry_pin == ila_pkg::FREE_PIN);
  assign res.pin_hit  = entry_valid && (entry_pin == req_pin);
  assign res.free_hit = entry_free && (lane_secure == req_secure);

endmodule

// File: design/ila_checker.sv
// ----------------------------------------------------------------------------
// ila_checker
// Port-level checks for the interrupt lane allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ila_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [ila_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] == ila_pkg::ST_OK) ||
                   (out_tdata[2:0] == ila_pkg::ST_LOOKUP) ||
                   (out_tdata[2:0] == ila_pkg::ST_MAPFAIL) ||
                   (out_tdata[2:0] == ila_pkg::ST_NOTMAPPED) ||
                   (out_tdata[2:0] == ila_pkg::ST_SECURITY))
    else $error("status code out of range");

  a_fail_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != ila_pkg::ST_OK) |-> out_tdata[7:3] == '0)
    else $error("failed request reports a lane");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while request in progress");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind interrupt_lane_allocator ila_checker u_ila_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
